[rtl/acfx_pkg.sv]
// Shared types, channel layout constants and message codes of the selection controller.
package acfx_pkg;

    localparam int AMP_CHANNELS = 4;
    localparam int CAB_CHANNELS = 4;
    localparam int FX_CHANNELS  = 4;
    localparam int ALL_CHANNELS = AMP_CHANNELS + CAB_CHANNELS + FX_CHANNELS;
    localparam int AMP_FIRST    = 0;
    localparam int CAB_FIRST    = AMP_CHANNELS;
    localparam int FX_FIRST     = AMP_CHANNELS + CAB_CHANNELS;

    localparam int OP_W   = 3;
    localparam int CH_W   = 4;
    localparam int IDX_W  = 2;
    localparam int MASK_W = 12;
    localparam int FXM_W  = 4;
    localparam int MSG_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_REFRESH   = 3'd0,
        OP_CABLE_IN  = 3'd1,
        OP_CABLE_OUT = 3'd2,
        OP_SELECT    = 3'd3,
        OP_DESELECT  = 3'd4,
        OP_CLICK     = 3'd5
    } op_t;

    typedef enum logic [MSG_W-1:0] {
        MSG_NONE    = 3'd0,
        MSG_CAB_OUT = 3'd1,
        MSG_NO_CAB  = 3'd2,
        MSG_AMP_OUT = 3'd3,
        MSG_NO_AMP  = 3'd4
    } msg_t;

    typedef struct packed {
        logic [MASK_W-1:0]      conn;
        logic                   amp_valid;
        logic [IDX_W-1:0]       amp_choice;
        logic                   cab_valid;
        logic [IDX_W-1:0]       cab_choice;
        logic [FX_CHANNELS-1:0] fx;
    } acfx_state_t;

    typedef struct packed {
        logic [MASK_W-1:0] relay_mask;
        logic [MASK_W-1:0] connected_mask;
        logic              amp_selected;
        logic [IDX_W-1:0]  amp_index;
        logic              cab_selected;
        logic [IDX_W-1:0]  cab_index;
        logic [FXM_W-1:0]  fx_mask;
        logic [MSG_W-1:0]  message;
        logic              error;
    } acfx_result_t;

endpackage

[rtl/acfx_evt_if.sv]
// Event channel interface: valid, ready and the op and channel fields.
interface acfx_evt_if;
    logic                     valid;
    logic                     ready;
    logic [acfx_pkg::OP_W-1:0] op;
    logic [acfx_pkg::CH_W-1:0] channel;

    modport source (output valid, output op, output channel, input ready);
    modport sink   (input valid, input op, input channel, output ready);
endinterface

[rtl/acfx_res_if.sv]
// Result channel interface: valid, ready and the result fields.
interface acfx_res_if;
    logic                         valid;
    logic                         ready;
    logic [acfx_pkg::MASK_W-1:0]  relay_mask;
    logic [acfx_pkg::MASK_W-1:0]  connected_mask;
    logic                         amp_selected;
    logic [acfx_pkg::IDX_W-1:0]   amp_index;
    logic                         cab_selected;
    logic [acfx_pkg::IDX_W-1:0]   cab_index;
    logic [acfx_pkg::FXM_W-1:0]   fx_mask;
    logic [acfx_pkg::MSG_W-1:0]   message;
    logic                         error;

    modport source (output valid, output relay_mask, output connected_mask,
                    output amp_selected, output amp_index, output cab_selected,
                    output cab_index, output fx_mask, output message, output error,
                    input ready);
    modport sink   (input valid, input relay_mask, input connected_mask,
                    input amp_selected, input amp_index, input cab_selected,
                    input cab_index, input fx_mask, input message, input error,
                    output ready);
endinterface

[rtl/acfx_core.sv]
// Combinational event update and consolidation of the selection state.
module acfx_core (
    input  acfx_pkg::acfx_state_t      state,
    input  logic [acfx_pkg::OP_W-1:0]  op,
    input  logic [acfx_pkg::CH_W-1:0]  channel,
    output acfx_pkg::acfx_state_t      state_next,
    output acfx_pkg::acfx_result_t     result
);

    always_comb
    begin
        logic [acfx_pkg::MASK_W-1:0]       conn;
        logic                              amp_v;
        logic [acfx_pkg::IDX_W-1:0]        amp_c;
        logic                              cab_v;
        logic [acfx_pkg::IDX_W-1:0]        cab_c;
        logic [acfx_pkg::FX_CHANNELS-1:0]  fx;
        logic [acfx_pkg::FX_CHANNELS-1:0]  fx_sel;
        logic [acfx_pkg::CH_W-1:0]         cab_off;
        logic [acfx_pkg::CH_W-1:0]         fx_off;
        logic                              in_range;
        logic                              plugged;
        logic                              err;
        logic [acfx_pkg::MSG_W-1:0]        msg;
        logic [acfx_pkg::MASK_W-1:0]       relays;
        logic [acfx_pkg::CH_W-1:0]         amp_ch;
        logic [acfx_pkg::CH_W-1:0]         cab_ch;

        conn     = state.conn;
        amp_v    = state.amp_valid;
        amp_c    = state.amp_choice;
        cab_v    = state.cab_valid;
        cab_c    = state.cab_choice;
        fx       = state.fx;
        err      = 1'b0;
        msg      = acfx_pkg::MSG_NONE;
        relays   = '0;
        in_range = channel < acfx_pkg::CH_W'(acfx_pkg::ALL_CHANNELS);
        plugged  = in_range && state.conn[channel];
        cab_off  = channel - acfx_pkg::CH_W'(acfx_pkg::CAB_FIRST);
        fx_off   = channel - acfx_pkg::CH_W'(acfx_pkg::FX_FIRST);
        fx_sel   = acfx_pkg::FX_CHANNELS'(1) << fx_off;

        case (op)
            acfx_pkg::OP_CABLE_IN:
            begin
                if (in_range)
                    conn[channel] = 1'b1;
            end
            acfx_pkg::OP_CABLE_OUT:
            begin
                if (in_range)
                    conn[channel] = 1'b0;
            end
            acfx_pkg::OP_SELECT, acfx_pkg::OP_DESELECT, acfx_pkg::OP_CLICK:
            begin
                if (in_range)
                begin
                    if (channel < acfx_pkg::CH_W'(acfx_pkg::CAB_FIRST))
                    begin
                        if (op != acfx_pkg::OP_DESELECT && plugged)
                        begin
                            amp_v = 1'b1;
                            amp_c = channel[acfx_pkg::IDX_W-1:0];
                        end
                    end
                    else if (channel < acfx_pkg::CH_W'(acfx_pkg::FX_FIRST))
                    begin
                        if (op != acfx_pkg::OP_DESELECT && plugged)
                        begin
                            cab_v = 1'b1;
                            cab_c = cab_off[acfx_pkg::IDX_W-1:0];
                        end
                    end
                    else if (op == acfx_pkg::OP_SELECT)
                    begin
                        if (plugged)
                            fx = fx | fx_sel;
                    end
                    else if (op == acfx_pkg::OP_DESELECT)
                    begin
                        fx = fx & ~fx_sel;
                    end
                    else if ((fx & fx_sel) != '0)
                    begin
                        fx = fx & ~fx_sel;
                    end
                    else if (plugged)
                    begin
                        fx = fx | fx_sel;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // A cab whose cable was pulled is dropped before the fallback search.
        cab_ch = acfx_pkg::CH_W'(acfx_pkg::CAB_FIRST) + acfx_pkg::CH_W'(cab_c);
        if (cab_v && !conn[cab_ch])
        begin
            cab_v = 1'b0;
            cab_c = '0;
            msg   = acfx_pkg::MSG_CAB_OUT;
            err   = 1'b1;
        end
        if (!cab_v)
        begin
            for (int i = acfx_pkg::CAB_CHANNELS - 1; i >= 0; i--)
            begin
                if (conn[acfx_pkg::CAB_FIRST + i])
                begin
                    cab_v = 1'b1;
                    cab_c = acfx_pkg::IDX_W'(i);
                end
            end
        end

        if (!cab_v)
        begin
            if (amp_v)
            begin
                amp_v = 1'b0;
                amp_c = '0;
                msg   = acfx_pkg::MSG_NO_CAB;
                err   = 1'b1;
            end
        end
        else
        begin
            amp_ch = acfx_pkg::CH_W'(acfx_pkg::AMP_FIRST) + acfx_pkg::CH_W'(amp_c);
            if (amp_v && !conn[amp_ch])
            begin
                amp_v = 1'b0;
                amp_c = '0;
                if (!err)
                begin
                    msg = acfx_pkg::MSG_AMP_OUT;
                    err = 1'b1;
                end
            end
            if (!amp_v)
            begin
                for (int i = acfx_pkg::AMP_CHANNELS - 1; i >= 0; i--)
                begin
                    if (conn[acfx_pkg::AMP_FIRST + i])
                    begin
                        amp_v = 1'b1;
                        amp_c = acfx_pkg::IDX_W'(i);
                    end
                end
            end
            if (!amp_v && !err)
            begin
                msg = acfx_pkg::MSG_NO_AMP;
                err = 1'b1;
            end
        end

        amp_ch = acfx_pkg::CH_W'(acfx_pkg::AMP_FIRST) + acfx_pkg::CH_W'(amp_c);
        cab_ch = acfx_pkg::CH_W'(acfx_pkg::CAB_FIRST) + acfx_pkg::CH_W'(cab_c);
        if (amp_v && conn[amp_ch])
            relays[amp_ch] = 1'b1;
        if (cab_v && conn[cab_ch])
            relays[cab_ch] = 1'b1;
        for (int i = 0; i < acfx_pkg::FX_CHANNELS; i++)
        begin
            if (fx[i] && conn[acfx_pkg::FX_FIRST + i])
                relays[acfx_pkg::FX_FIRST + i] = 1'b1;
        end

        state_next.conn       = conn;
        state_next.amp_valid  = amp_v;
        state_next.amp_choice = amp_c;
        state_next.cab_valid  = cab_v;
        state_next.cab_choice = cab_c;
        state_next.fx         = fx;

        result.relay_mask     = relays;
        result.connected_mask = conn;
        result.amp_selected   = amp_v;
        result.amp_index      = amp_v ? amp_c : '0;
        result.cab_selected   = cab_v;
        result.cab_index      = cab_v ? cab_c : '0;
        result.fx_mask        = acfx_pkg::FXM_W'(fx);
        result.message        = msg;
        result.error          = err;
    end

endmodule

[rtl/amp_cab_fx_selection_controller_unit.sv]
// Top level of the amp, cab and effect selection controller.
// Accepted events enter the input stage; their results then load the result register.
// Throughput: one event per cycle unless res.ready stalls the output; the selection
// state is updated in the same cycle the result register loads, so the next event
// sees it at once. Reset (rst_n low, asynchronous) clears the connected mask,
// both choices, the effect bits and both pipeline valid flags.
module amp_cab_fx_selection_controller_unit (
    input  logic               clk,
    input  logic               rst_n,
    acfx_evt_if.sink           evt,
    acfx_res_if.source         res
);

    logic                           s1_valid_reg;
    logic [acfx_pkg::OP_W-1:0]      s1_op_reg;
    logic [acfx_pkg::CH_W-1:0]      s1_channel_reg;
    acfx_pkg::acfx_state_t          state_reg;
    acfx_pkg::acfx_state_t          state_next;
    acfx_pkg::acfx_result_t         result_next;
    acfx_pkg::acfx_result_t         result_reg;
    logic                           out_valid_reg;
    logic                           advance;

    // The input stage moves on whenever the result register is free or being drained.
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !s1_valid_reg || advance;

    acfx_core u_core (
        .state      (state_reg),
        .op         (s1_op_reg),
        .channel    (s1_channel_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (evt.ready)
                s1_valid_reg <= evt.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            s1_op_reg      <= evt.op;
            s1_channel_reg <= evt.channel;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.relay_mask     = result_reg.relay_mask;
    assign res.connected_mask = result_reg.connected_mask;
    assign res.amp_selected   = result_reg.amp_selected;
    assign res.amp_index      = result_reg.amp_index;
    assign res.cab_selected   = result_reg.cab_selected;
    assign res.cab_index      = result_reg.cab_index;
    assign res.fx_mask        = result_reg.fx_mask;
    assign res.message        = result_reg.message;
    assign res.error          = result_reg.error;

    a_amp_needs_cab: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.amp_valid |-> state_reg.cab_valid)
        else $error("amp chosen while no cab is chosen");

    a_error_matches_message: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.error == (result_reg.message != acfx_pkg::MSG_NONE)))
        else $error("error flag disagrees with message code");

    a_relay_needs_cable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((result_reg.relay_mask & ~result_reg.connected_mask) == '0))
        else $error("relay energized on an unplugged channel");

    a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> (out_valid_reg && $stable(result_reg)))
        else $error("stalled result register changed");

endmodule

[sim/amp_cab_fx_selection_controller_unit_test.sv]
// Self-checking testbench of the selection controller: directed events, then random traffic.
module amp_cab_fx_selection_controller_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import acfx_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
    localparam int RANDOM_EVENTS = 1700;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CH_W-1:0] channel;
        logic            typed;
        acfx_result_t    want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic ev_valid = 1'b0;
    logic [OP_W-1:0] ev_op = '0;
    logic [CH_W-1:0] ev_ch = '0;
    logic rdy = 1'b0;
    bit steady = 1'b0;

    int cycles = 0;
    int errors = 0;
    int events_sent = 0;
    int results_seen = 0;
    int flagged_seen = 0;

    // Predictor copy of the panel state.
    logic [MASK_W-1:0]      conn_now = '0;
    logic                   amp_on = 1'b0;
    logic [IDX_W-1:0]       amp_sel = '0;
    logic                   cab_on = 1'b0;
    logic [IDX_W-1:0]       cab_sel = '0;
    logic [FX_CHANNELS-1:0] fx_now = '0;

    acfx_result_t predicted_status[$];
    script_row_t  script[$];

    acfx_evt_if evt ();
    acfx_res_if res ();

    assign evt.valid   = ev_valid;
    assign evt.op      = ev_op;
    assign evt.channel = ev_ch;
    assign res.ready   = rdy;

    amp_cab_fx_selection_controller_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies one event to the panel state, then consolidates the choices.
    task automatic advance_panel(input logic [OP_W-1:0] o, input logic [CH_W-1:0] c,
                                 output acfx_result_t r);
        int chi;
        int fi;
        msg_t msg;
        logic err;
        logic found;
        logic [MASK_W-1:0] relays;
        chi = int'(c);
        msg = MSG_NONE;
        err = 1'b0;
        relays = '0;
        case (o)
            OP_CABLE_IN:
                if (chi < ALL_CHANNELS)
                    conn_now[chi] = 1'b1;
            OP_CABLE_OUT:
                if (chi < ALL_CHANNELS)
                    conn_now[chi] = 1'b0;
            OP_SELECT, OP_DESELECT, OP_CLICK:
                if (chi < ALL_CHANNELS)
                begin
                    if (chi < CAB_FIRST)
                    begin
                        if (o != OP_DESELECT && conn_now[chi])
                        begin
                            amp_on = 1'b1;
                            amp_sel = IDX_W'(chi - AMP_FIRST);
                        end
                    end
                    else if (chi < FX_FIRST)
                    begin
                        if (o != OP_DESELECT && conn_now[chi])
                        begin
                            cab_on = 1'b1;
                            cab_sel = IDX_W'(chi - CAB_FIRST);
                        end
                    end
                    else
                    begin
                        fi = chi - FX_FIRST;
                        if (o == OP_SELECT)
                        begin
                            if (conn_now[chi])
                                fx_now[fi] = 1'b1;
                        end
                        else if (o == OP_DESELECT)
                            fx_now[fi] = 1'b0;
                        else if (fx_now[fi])
                            fx_now[fi] = 1'b0;
                        else if (conn_now[chi])
                            fx_now[fi] = 1'b1;
                    end
                end
            default: ;
        endcase

        if (cab_on && !conn_now[CAB_FIRST + int'(cab_sel)])
        begin
            cab_on = 1'b0;
            cab_sel = '0;
            msg = MSG_CAB_OUT;
            err = 1'b1;
        end
        if (!cab_on)
        begin
            found = 1'b0;
            for (int i = 0; i < CAB_CHANNELS; i++)
                if (!found && conn_now[CAB_FIRST + i])
                begin
                    found = 1'b1;
                    cab_on = 1'b1;
                    cab_sel = IDX_W'(i);
                end
        end
        if (!cab_on)
        begin
            // Without a cab no amp may stay selected.
            if (amp_on)
            begin
                amp_on = 1'b0;
                amp_sel = '0;
                msg = MSG_NO_CAB;
                err = 1'b1;
            end
        end
        else
        begin
            if (amp_on && !conn_now[AMP_FIRST + int'(amp_sel)])
            begin
                amp_on = 1'b0;
                amp_sel = '0;
                if (!err)
                begin
                    msg = MSG_AMP_OUT;
                    err = 1'b1;
                end
            end
            if (!amp_on)
            begin
                found = 1'b0;
                for (int i = 0; i < AMP_CHANNELS; i++)
                    if (!found && conn_now[AMP_FIRST + i])
                    begin
                        found = 1'b1;
                        amp_on = 1'b1;
                        amp_sel = IDX_W'(i);
                    end
            end
            if (!amp_on && !err)
            begin
                msg = MSG_NO_AMP;
                err = 1'b1;
            end
        end

        if (amp_on && conn_now[AMP_FIRST + int'(amp_sel)])
            relays[AMP_FIRST + int'(amp_sel)] = 1'b1;
        if (cab_on && conn_now[CAB_FIRST + int'(cab_sel)])
            relays[CAB_FIRST + int'(cab_sel)] = 1'b1;
        for (int i = 0; i < FX_CHANNELS; i++)
            if (fx_now[i] && conn_now[FX_FIRST + i])
                relays[FX_FIRST + i] = 1'b1;

        r.relay_mask     = relays;
        r.connected_mask = conn_now;
        r.amp_selected   = amp_on;
        r.amp_index      = amp_on ? amp_sel : '0;
        r.cab_selected   = cab_on;
        r.cab_index      = cab_on ? cab_sel : '0;
        r.fx_mask        = fx_now;
        r.message        = msg;
        r.error          = err;
    endtask

    // Drives one event and waits for its transaction; the expectation is queued on acceptance.
    task automatic send_event(input logic [OP_W-1:0] o, input logic [CH_W-1:0] c,
                              input logic typed, input acfx_result_t want);
        int gap;
        acfx_result_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            ev_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_valid <= 1'b1;
        ev_op    <= o;
        ev_ch    <= c;
        @(posedge clk);
        while (!evt.ready)
            @(posedge clk);
        advance_panel(o, c, pred);
        predicted_status.push_back(typed ? want : pred);
        events_sent++;
    endtask

    // Result side: random stalls on ready, and the field-by-field check.
    always @(posedge clk)
    begin
        int stall_left;
        int g;
        acfx_result_t got;
        acfx_result_t want;
        if (rst_n && res.valid && rdy)
        begin
            got.relay_mask     = res.relay_mask;
            got.connected_mask = res.connected_mask;
            got.amp_selected   = res.amp_selected;
            got.amp_index      = res.amp_index;
            got.cab_selected   = res.cab_selected;
            got.cab_index      = res.cab_index;
            got.fx_mask        = res.fx_mask;
            got.message        = res.message;
            got.error          = res.error;
            results_seen++;
            if (got.error === 1'b1)
                flagged_seen++;
            if (predicted_status.size() == 0)
            begin
                $error("result transaction with no event waiting: %h", got);
                errors++;
            end
            else
            begin
                want = predicted_status.pop_front();
                if (got.relay_mask !== want.relay_mask)
                begin
                    $error("relay_mask: expected %h, got %h", want.relay_mask, got.relay_mask);
                    errors++;
                end
                if (got.connected_mask !== want.connected_mask)
                begin
                    $error("connected_mask: expected %h, got %h",
                           want.connected_mask, got.connected_mask);
                    errors++;
                end
                if (got.amp_selected !== want.amp_selected)
                begin
                    $error("amp_selected: expected %b, got %b",
                           want.amp_selected, got.amp_selected);
                    errors++;
                end
                if (got.amp_index !== want.amp_index)
                begin
                    $error("amp_index: expected %0d, got %0d", want.amp_index, got.amp_index);
                    errors++;
                end
                if (got.cab_selected !== want.cab_selected)
                begin
                    $error("cab_selected: expected %b, got %b",
                           want.cab_selected, got.cab_selected);
                    errors++;
                end
                if (got.cab_index !== want.cab_index)
                begin
                    $error("cab_index: expected %0d, got %0d", want.cab_index, got.cab_index);
                    errors++;
                end
                if (got.fx_mask !== want.fx_mask)
                begin
                    $error("fx_mask: expected %h, got %h", want.fx_mask, got.fx_mask);
                    errors++;
                end
                if (got.message !== want.message)
                begin
                    $error("message: expected %0d, got %0d", want.message, got.message);
                    errors++;
                end
                if (got.error !== want.error)
                begin
                    $error("error: expected %b, got %b", want.error, got.error);
                    errors++;
                end
            end
        end
        if (!rst_n)
            rdy <= 1'b0;
        else if (stall_left > 0)
        begin
            rdy <= 1'b0;
            stall_left--;
        end
        else
        begin
            g = pick_gap();
            if (g == 0)
                rdy <= 1'b1;
            else
            begin
                rdy <= 1'b0;
                stall_left = g - 1;
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("amp_cab_fx_selection_controller_unit_test: FAIL");
        $finish;
    end

    initial
    begin
        int pick;
        logic [OP_W-1:0] o;
        logic [CH_W-1:0] c;

        // Directed events, run from the reset state; typed rows are read straight off the rules.
        script.push_back('{OP_REFRESH,   4'd0,  1'b1,
                           '{12'h000, 12'h000, 1'b0, 2'd0, 1'b0, 2'd0, 4'h0, MSG_NONE, 1'b0}});
        script.push_back('{OP_RSVD_7,    4'd15, 1'b1,
                           '{12'h000, 12'h000, 1'b0, 2'd0, 1'b0, 2'd0, 4'h0, MSG_NONE, 1'b0}});
        script.push_back('{OP_SELECT,    4'd0,  1'b1,
                           '{12'h000, 12'h000, 1'b0, 2'd0, 1'b0, 2'd0, 4'h0, MSG_NONE, 1'b0}});
        script.push_back('{OP_CABLE_IN,  4'd0,  1'b1,
                           '{12'h000, 12'h001, 1'b0, 2'd0, 1'b0, 2'd0, 4'h0, MSG_NONE, 1'b0}});
        script.push_back('{OP_SELECT,    4'd0,  1'b1,
                           '{12'h000, 12'h001, 1'b0, 2'd0, 1'b0, 2'd0, 4'h0, MSG_NO_CAB, 1'b1}});
        script.push_back('{OP_CABLE_IN,  4'd7,  1'b0, '0});
        script.push_back('{OP_CABLE_IN,  4'd4,  1'b0, '0});
        script.push_back('{OP_SELECT,    4'd4,  1'b0, '0});
        script.push_back('{OP_CABLE_OUT, 4'd4,  1'b1,
                           '{12'h081, 12'h081, 1'b1, 2'd0, 1'b1, 2'd3, 4'h0, MSG_CAB_OUT, 1'b1}});
        script.push_back('{OP_CABLE_IN,  4'd3,  1'b0, '0});
        script.push_back('{OP_CLICK,     4'd3,  1'b0, '0});
        script.push_back('{OP_CABLE_OUT, 4'd3,  1'b0, '0});
        script.push_back('{OP_CABLE_OUT, 4'd0,  1'b1,
                           '{12'h080, 12'h080, 1'b0, 2'd0, 1'b1, 2'd3, 4'h0, MSG_AMP_OUT, 1'b1}});
        script.push_back('{OP_REFRESH,   4'd0,  1'b1,
                           '{12'h080, 12'h080, 1'b0, 2'd0, 1'b1, 2'd3, 4'h0, MSG_NO_AMP, 1'b1}});
        script.push_back('{OP_CLICK,     4'd8,  1'b0, '0});
        script.push_back('{OP_CABLE_IN,  4'd8,  1'b0, '0});
        script.push_back('{OP_CLICK,     4'd8,  1'b0, '0});
        script.push_back('{OP_CABLE_IN,  4'd11, 1'b0, '0});
        script.push_back('{OP_SELECT,    4'd11, 1'b0, '0});
        script.push_back('{OP_CABLE_OUT, 4'd8,  1'b0, '0});
        script.push_back('{OP_CLICK,     4'd8,  1'b0, '0});
        script.push_back('{OP_DESELECT,  4'd11, 1'b0, '0});
        script.push_back('{OP_DESELECT,  4'd7,  1'b0, '0});
        script.push_back('{OP_CABLE_IN,  4'd1,  1'b0, '0});
        script.push_back('{OP_CABLE_OUT, 4'd7,  1'b1,
                           '{12'h000, 12'h802, 1'b0, 2'd0, 1'b0, 2'd0, 4'h0, MSG_NO_CAB, 1'b1}});
        script.push_back('{OP_RSVD_6,    4'd12, 1'b0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
            send_event(script[k].op, script[k].channel, script[k].typed, script[k].want);

        for (int n = 0; n < RANDOM_EVENTS; n++)
        begin
            // Every hundred events, sometimes run a stretch with no idling on either side.
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_EVENTS / 2)
            begin
                // Let the pipeline run dry before carrying on.
                ev_valid <= 1'b0;
                @(posedge clk);
                while (predicted_status.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                o = OP_REFRESH;
            else if (pick < 33)
                o = OP_CABLE_IN;
            else if (pick < 53)
                o = OP_CABLE_OUT;
            else if (pick < 73)
                o = OP_SELECT;
            else if (pick < 83)
                o = OP_DESELECT;
            else if (pick < 96)
                o = OP_CLICK;
            else if (pick < 98)
                o = OP_RSVD_6;
            else
                o = OP_RSVD_7;
            if ($urandom_range(0, 19) == 0)
                c = CH_W'($urandom_range(ALL_CHANNELS, 15));
            else
                c = CH_W'($urandom_range(0, ALL_CHANNELS - 1));
            send_event(o, c, 1'b0, '0);
        end
        ev_valid <= 1'b0;

        while (predicted_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d channel events (directed and random) and checked %0d results,",
                 events_sent, results_seen);
        $display("of which %0d carried a consolidation message, under random stalls.",
                 flagged_seen);
        if (errors == 0)
            $display("amp_cab_fx_selection_controller_unit_test: PASS");
        else
            $display("amp_cab_fx_selection_controller_unit_test: FAIL");
        $finish;
    end

endmodule
